// File: rtl/streaming_dedup_watermark_table_assert.svh
// Assertion macros shared by the table RTL.
`ifndef STREAMING_DEDUP_WATERMARK_TABLE_ASSERT_SVH
`define STREAMING_DEDUP_WATERMARK_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SDWT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table assertion failed");
`define SDWT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table assertion failed");
`else
`define SDWT_ASSERT_SAME(lbl, ante, cons)
`define SDWT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/sdwt_pkg.sv
package sdwt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic eq;
        logic ge;
    } cmp_res_t;

    localparam logic [2:0] VERDICT_KEPT     = 3'd0;
    localparam logic [2:0] VERDICT_DUP      = 3'd1;
    localparam logic [2:0] VERDICT_LATE     = 3'd2;
    localparam logic [2:0] VERDICT_OVERFLOW = 3'd3;
    localparam logic [2:0] VERDICT_FULL     = 3'd4;
    localparam logic [2:0] VERDICT_EVICT    = 3'd5;

    localparam logic [1:0] CFG_WATERMARK_MODE = 2'd0;
    localparam logic [1:0] CFG_LATE_CHECK     = 2'd1;
    localparam logic [1:0] CFG_LATE_WATERMARK = 2'd2;
    localparam logic [1:0] CFG_DELAY          = 2'd3;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

endpackage

// File: rtl/streaming_dedup_watermark_table.sv
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   mode, key, event_time, evict_watermark
// output    out        out_valid/out_stall verdict, removed_count, total_entries
// config    in         cfg_we              cfg_index, cfg_data
//
// A row or evict word scans every entry of the table: one entry of the table per cycle goes
// through the single read port of the entry memory and the shared compare unit.
// A late row skips the scan and goes straight to commit. The block takes one word at a time (in_stall high while busy).
// Reset clears valid bits, count and config at once; no clearing pass.
// A result stalled at the output holds the next word in commit until it is taken.
module streaming_dedup_watermark_table
    import sdwt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int KEY_BITS = 64,
    localparam int IDX_W = $clog2(TABLE_ENTRIES),
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [63:0]        key,
    input  logic signed [63:0] event_time,
    input  logic signed [63:0] evict_watermark,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         verdict,
    output logic [CNT_W-1:0]   removed_count,
    output logic [CNT_W-1:0]   total_entries
);

`include "streaming_dedup_watermark_table_assert.svh"

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t state_reg, state_next;

    logic        wm_mode_reg, late_en_reg;
    logic [63:0] late_wm_reg;
    logic [62:0] delay_reg;

    logic                mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [63:0]         ewm_b_reg, ewm_b_next;
    logic [63:0]         expiry_reg, expiry_next;
    logic                ovf_reg, ovf_next;
    logic                late_reg, late_next;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             chk_live_reg, chk_live_next;
    logic             found_reg, found_next;
    logic             have_free_reg, have_free_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       verdict_reg, verdict_next;
    logic [CNT_W-1:0] removed_out_reg, removed_out_next;
    logic [CNT_W-1:0] total_reg, total_next;

    logic                in_accept;
    logic                commit_go;
    logic                ins_en;
    logic                evict_hit;
    logic [2:0]          commit_verdict;
    logic [64:0]         expiry_sum;
    logic [63:0]         cmp_a, cmp_b;
    cmp_res_t            cmp_res;
    logic [KEY_BITS-1:0] rd_key;
    logic [63:0]         rd_expiry;
    logic                rd_timed;

    sdwt_entry_mem #(
        .DEPTH (TABLE_ENTRIES),
        .KEY_W (KEY_BITS)
    ) u_mem (
        .clk       (clk),
        .we        (ins_en),
        .wr_addr   (free_slot_reg),
        .wr_key    (key_reg),
        .wr_expiry (expiry_reg),
        .wr_timed  (wm_mode_reg),
        .rd_addr   (scan_idx_reg),
        .rd_key    (rd_key),
        .rd_expiry (rd_expiry),
        .rd_timed  (rd_timed)
    );

    sdwt_cmp_unit u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm_mode_reg <= 1'b0;
            late_en_reg <= 1'b0;
            late_wm_reg <= 64'd0;
            delay_reg   <= 63'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WATERMARK_MODE: wm_mode_reg <= cfg_data[0];
                CFG_LATE_CHECK:     late_en_reg <= cfg_data[0];
                CFG_LATE_WATERMARK: late_wm_reg <= cfg_data;
                CFG_DELAY:          delay_reg   <= cfg_data[62:0];
                default:            ;
            endcase
        end
    end

    assign in_accept = in_valid && !in_stall;
    assign commit_go = (state_reg == ST_COMMIT) && !(out_valid_reg && out_stall);
    assign expiry_sum = {1'b0, 64'(event_time) ^ SIGN_BIT} + {2'b00, delay_reg};

    always_comb
    begin
        if (late_reg)
            commit_verdict = VERDICT_LATE;
        else if (mode_reg)
            commit_verdict = VERDICT_EVICT;
        else if (found_reg)
            commit_verdict = VERDICT_DUP;
        else if (wm_mode_reg && ovf_reg)
            commit_verdict = VERDICT_OVERFLOW;
        else if (!have_free_reg)
            commit_verdict = VERDICT_FULL;
        else
            commit_verdict = VERDICT_KEPT;
    end

    assign ins_en = commit_go && (commit_verdict == VERDICT_KEPT);
    // timed flag lives in the entry memory; the valid bit gates every read of it
    assign evict_hit = chk_live_reg && mode_reg && valid_reg[chk_idx_reg] &&
                       rd_timed && cmp_res.ge;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = late_next ? ST_COMMIT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (chk_live_reg && chk_idx_reg == LAST_IDX)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake and compare operand select
    always_comb
    begin
        in_stall = 1'b1;
        cmp_a    = 64'd0;
        cmp_b    = 64'd0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmp_a    = late_wm_reg ^ SIGN_BIT;
                cmp_b    = 64'(event_time) ^ SIGN_BIT;
            end
            ST_SCAN:
            begin
                if (mode_reg)
                begin
                    cmp_a = ewm_b_reg;
                    cmp_b = rd_expiry ^ SIGN_BIT;
                end
                else
                begin
                    cmp_a = 64'(key_reg);
                    cmp_b = 64'(rd_key);
                end
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb
    begin
        mode_next       = mode_reg;
        key_next        = key_reg;
        ewm_b_next      = ewm_b_reg;
        expiry_next     = expiry_reg;
        ovf_next        = ovf_reg;
        late_next       = !mode && wm_mode_reg && late_en_reg && cmp_res.ge;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        chk_idx_next    = chk_idx_reg;
        chk_live_next   = 1'b0;
        found_next      = found_reg;
        have_free_next  = have_free_reg;
        free_slot_next  = free_slot_reg;
        removed_next    = removed_reg;
        count_next      = count_reg;

        if (in_accept)
        begin
            mode_next       = mode;
            key_next        = key[KEY_BITS-1:0];
            ewm_b_next      = 64'(evict_watermark) ^ SIGN_BIT;
            expiry_next     = expiry_sum[63:0] ^ SIGN_BIT;
            ovf_next        = expiry_sum[64];
            scan_idx_next   = '0;
            issue_done_next = 1'b0;
            found_next      = 1'b0;
            have_free_next  = 1'b0;
            free_slot_next  = '0;
            removed_next    = '0;
        end

        if (state_reg == ST_SCAN)
        begin
            // issue one read per cycle, check it the cycle after
            if (!issue_done_reg)
            begin
                chk_live_next   = 1'b1;
                chk_idx_next    = scan_idx_reg;
                scan_idx_next   = scan_idx_reg + 1'b1;
                issue_done_next = (scan_idx_reg == LAST_IDX);
            end
            if (chk_live_reg && !mode_reg)
            begin
                if (valid_reg[chk_idx_reg])
                begin
                    if (cmp_res.eq)
                        found_next = 1'b1;
                end
                else if (!have_free_reg)
                begin
                    have_free_next = 1'b1;
                    free_slot_next = chk_idx_reg;
                end
            end
            if (evict_hit)
            begin
                removed_next = removed_reg + 1'b1;
                count_next   = count_reg - 1'b1;
            end
        end

        if (ins_en)
            count_next = count_reg + 1'b1;
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        verdict_next     = verdict_reg;
        removed_out_next = removed_out_reg;
        total_next       = total_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (commit_go)
        begin
            out_valid_next   = 1'b1;
            verdict_next     = commit_verdict;
            removed_out_next = (commit_verdict == VERDICT_EVICT) ? removed_reg : '0;
            total_next       = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_done_reg <= 1'b0;
            chk_live_reg   <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            late_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            chk_live_reg   <= chk_live_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            if (in_accept)
                late_reg <= late_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        ewm_b_reg       <= ewm_b_next;
        expiry_reg      <= expiry_next;
        ovf_reg         <= ovf_next;
        scan_idx_reg    <= scan_idx_next;
        chk_idx_reg     <= chk_idx_next;
        found_reg       <= found_next;
        have_free_reg   <= have_free_next;
        free_slot_reg   <= free_slot_next;
        removed_reg     <= removed_next;
        verdict_reg     <= verdict_next;
        removed_out_reg <= removed_out_next;
        total_reg       <= total_next;
    end

    // entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (evict_hit)
        begin
            valid_reg[chk_idx_reg] <= 1'b0;
        end
        else if (ins_en)
        begin
            valid_reg[free_slot_reg] <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign verdict       = verdict_reg;
    assign removed_count = removed_out_reg;
    assign total_entries = total_reg;

    `SDWT_ASSERT_SAME(a_count_range, 1'b1, count_reg <= CNT_W'(TABLE_ENTRIES))
    `SDWT_ASSERT_SAME(a_check_in_scan, chk_live_reg, state_reg == ST_SCAN)
    `SDWT_ASSERT_NEXT(a_insert_counts, ins_en, count_reg == $past(count_reg) + 1'b1)
    `SDWT_ASSERT_SAME(a_row_no_removed, out_valid_reg && verdict_reg != VERDICT_EVICT, removed_out_reg == '0)

endmodule

// File: rtl/sdwt_entry_mem.sv
module sdwt_entry_mem #(
    parameter int DEPTH = 256,
    parameter int KEY_W = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_key,
    input  logic [63:0]       wr_expiry,
    input  logic              wr_timed,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_key,
    output logic [63:0]       rd_expiry,
    output logic              rd_timed
);

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [63:0]      exp_mem [DEPTH];
    logic             timed_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[wr_addr]   <= wr_key;
            exp_mem[wr_addr]   <= wr_expiry;
            timed_mem[wr_addr] <= wr_timed;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key    <= key_mem[rd_addr];
        rd_expiry <= exp_mem[rd_addr];
        rd_timed  <= timed_mem[rd_addr];
    end

endmodule

// File: rtl/sdwt_cmp_unit.sv
module sdwt_cmp_unit
    import sdwt_pkg::*;
(
    input  logic [63:0] a,
    input  logic [63:0] b,
    output cmp_res_t    res
);

    logic [64:0] diff;

    // one subtractor serves both equality and unsigned order
    assign diff   = {1'b0, a} - {1'b0, b};
    assign res.ge = ~diff[64];
    assign res.eq = (diff[63:0] == 64'd0);

endmodule
